>>> hdl/cell_balance_sequencer_assert.svh
// assertion macros for the cell balance sequencer
// depends on nothing; included by modules that carry concurrent checks
`ifndef CELL_BALANCE_SEQUENCER_ASSERT_SVH
`define CELL_BALANCE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

`define CBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cbs check failed");

`define CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cbs check failed");

`else

`define CBS_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/cbs_pkg.sv
// shared types and constants for the cell balance sequencer
// no dependencies
`timescale 1ns / 1ps

package cbs_pkg;

    localparam int MV_W       = 13;
    localparam int SETTLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int PHASE_W    = 3;

    localparam logic [PHASE_W-1:0] PH_INITIAL = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SETTLE  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_READ    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RESTORE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL      = 3'd3;

    localparam logic [MV_W-1:0]     RST_HIGH_LEVEL    = 13'd4200;
    localparam logic [MV_W-1:0]     RST_RELEASE_LEVEL = 13'd4100;
    localparam logic [SETTLE_W-1:0] RST_SETTLE        = 16'd100;
    localparam logic [TIME_W-1:0]   RST_INTERVAL      = 32'd1000;

    localparam logic ACT_POLL = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] now_ms;
        logic [MV_W-1:0]   cell_mv;
        logic              balance_request;
    } t_req;

    typedef struct packed {
        logic               balancer_on;
        logic [PHASE_W-1:0] phase;
        logic [MV_W-1:0]    last_mv;
        logic               over_latched;
    } t_rsp;

endpackage

>>> hdl/cell_balance_sequencer.sv
// cell balance sequencer top level: request register, sequencer update, result register
// depends on cbs_pkg and cell_balance_sequencer_assert.svh
`timescale 1ns / 1ps
`include "cell_balance_sequencer_assert.svh"

// Passive cell-balancing sequencer.
// Input channel: i_in_valid / o_in_stall with payload i_in_data. A request is
// either a poll (one step of the initial, settle, read, restore, wait
// sequence) or a host write of the balancer drive.
// Output channel: o_out_valid / i_out_stall with payload o_out_data; every
// request gives exactly one result: drive, phase, last sample and latch
// after that request.
// Registers: request register, then sequencer state and result register updated together.
// Throughput: one request per cycle while the result is not stalled, set by the state
// update between the request register and the result register.
// Stall: while the result is stalled, one more request is held in the
// request register; after that o_in_stall rises until the result is taken.
// Reset (i_rst_n low, synchronous): phase initial, drive off, latch and
// sample zero, registers back to 4200/4100/100/1000.
// Configuration: i_cfg_we writes register i_cfg_index (0..3) from
// i_cfg_data; higher indexes are ignored. Write only while idle.
module cell_balance_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  cbs_pkg::t_req                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output cbs_pkg::t_rsp                    o_out_data,
    input  logic                             i_cfg_we,
    input  logic [cbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [cbs_pkg::MV_W-1:0]     r_high_level;
    logic [cbs_pkg::MV_W-1:0]     r_release_level;
    logic [cbs_pkg::SETTLE_W-1:0] r_settle;
    logic [cbs_pkg::TIME_W-1:0]   r_interval;

    logic                         r_in_valid;
    cbs_pkg::t_req                r_in_data;
    logic                         r_out_valid;
    cbs_pkg::t_rsp                r_out_data;

    logic [cbs_pkg::PHASE_W-1:0]  r_phase;
    logic [cbs_pkg::TIME_W-1:0]   r_cycle_start;
    logic                         r_planned;
    logic                         r_latch;
    logic                         r_drive;
    logic [cbs_pkg::MV_W-1:0]     r_sample;

    logic [cbs_pkg::PHASE_W-1:0]  n_phase;
    logic [cbs_pkg::TIME_W-1:0]   n_cycle_start;
    logic                         n_planned;
    logic                         n_latch;
    logic                         n_drive;
    logic [cbs_pkg::MV_W-1:0]     n_sample;

    logic                         w_advance;
    logic [cbs_pkg::TIME_W-1:0]   w_elapsed;

    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_elapsed   = r_in_data.now_ms - r_cycle_start;

    always_comb begin
        n_phase       = r_phase;
        n_cycle_start = r_cycle_start;
        n_planned     = r_planned;
        n_latch       = r_latch;
        n_drive       = r_drive;
        n_sample      = r_sample;
        if (r_in_data.action == cbs_pkg::ACT_SET) begin
            n_drive = r_in_data.balance_request;
        end else begin
            case (r_phase)
                cbs_pkg::PH_SETTLE: begin
                    if (w_elapsed >= {{(cbs_pkg::TIME_W-cbs_pkg::SETTLE_W){1'b0}}, r_settle})
                    begin
                        n_phase = cbs_pkg::PH_READ;
                    end
                end
                cbs_pkg::PH_READ: begin
                    n_sample = r_in_data.cell_mv;
                    if (r_in_data.cell_mv >= r_high_level || r_latch) begin
                        if (r_in_data.cell_mv <= r_release_level) begin
                            n_latch   = 1'b0;
                            n_planned = 1'b0;
                        end else begin
                            n_latch   = 1'b1;
                            n_planned = 1'b1;
                        end
                    end
                    n_phase = cbs_pkg::PH_RESTORE;
                end
                cbs_pkg::PH_RESTORE: begin
                    n_drive = r_planned;
                    n_phase = cbs_pkg::PH_WAIT;
                end
                cbs_pkg::PH_WAIT: begin
                    if (w_elapsed >= r_interval) begin
                        n_phase = cbs_pkg::PH_INITIAL;
                    end
                end
                default: begin
                    n_planned     = r_drive;
                    n_drive       = 1'b0;
                    n_phase       = r_drive ? cbs_pkg::PH_SETTLE : cbs_pkg::PH_READ;
                    n_cycle_start = r_in_data.now_ms;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_level    <= cbs_pkg::RST_HIGH_LEVEL;
            r_release_level <= cbs_pkg::RST_RELEASE_LEVEL;
            r_settle        <= cbs_pkg::RST_SETTLE;
            r_interval      <= cbs_pkg::RST_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cbs_pkg::CFG_HIGH_LEVEL:    r_high_level    <= i_cfg_data[cbs_pkg::MV_W-1:0];
                cbs_pkg::CFG_RELEASE_LEVEL: r_release_level <= i_cfg_data[cbs_pkg::MV_W-1:0];
                cbs_pkg::CFG_SETTLE:        r_settle        <= i_cfg_data[cbs_pkg::SETTLE_W-1:0];
                cbs_pkg::CFG_INTERVAL:      r_interval      <= i_cfg_data[cbs_pkg::TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= cbs_pkg::PH_INITIAL;
            r_cycle_start <= '0;
            r_planned     <= 1'b0;
            r_latch       <= 1'b0;
            r_drive       <= 1'b0;
            r_sample      <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid   <= 1'b1;
                r_phase       <= n_phase;
                r_cycle_start <= n_cycle_start;
                r_planned     <= n_planned;
                r_latch       <= n_latch;
                r_drive       <= n_drive;
                r_sample      <= n_sample;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
        if (w_advance) begin
            r_out_data.balancer_on  <= n_drive;
            r_out_data.phase        <= n_phase;
            r_out_data.last_mv      <= n_sample;
            r_out_data.over_latched <= n_latch;
        end
    end

    // checks
    `CBS_ASSERT_IMPL(a_no_stall_when_empty, i_clk, i_rst_n, !r_in_valid, !o_in_stall)
    `CBS_ASSERT_NEXT(a_advance_loads_result, i_clk, i_rst_n, w_advance, r_out_valid)
    `CBS_ASSERT_NEXT(a_settle_goes_to_read, i_clk, i_rst_n,
        w_advance && r_in_data.action == cbs_pkg::ACT_POLL && r_phase == cbs_pkg::PH_SETTLE,
        r_phase == cbs_pkg::PH_SETTLE || r_phase == cbs_pkg::PH_READ)
    `CBS_ASSERT_NEXT(a_initial_drops_drive, i_clk, i_rst_n,
        w_advance && r_in_data.action == cbs_pkg::ACT_POLL && r_phase == cbs_pkg::PH_INITIAL,
        !r_drive && r_planned == $past(r_drive))

endmodule

>>> test/tb_cell_balance_sequencer.sv
`timescale 1ns / 1ps
// testbench for cell_balance_sequencer: directed and random poll and set requests,
// each result checked against a behavioral model of the phase sequencer and hysteresis
// depends on cbs_pkg and the cell_balance_sequencer rtl
module tb_cell_balance_sequencer;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 8;
    localparam logic [cbs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    cbs_pkg::t_req                  in_data;
    logic                           out_valid;
    logic                           out_stall;
    cbs_pkg::t_rsp                  out_data;
    logic                           cfg_we;
    logic [cbs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cbs_pkg::CFG_DATA_W-1:0] cfg_data;

    // model copy of the registers and sequencer state
    logic [cbs_pkg::MV_W-1:0]     lim_high_mv;
    logic [cbs_pkg::MV_W-1:0]     lim_release_mv;
    logic [cbs_pkg::SETTLE_W-1:0] lim_settle_ms;
    logic [cbs_pkg::TIME_W-1:0]   lim_interval_ms;
    logic [cbs_pkg::PHASE_W-1:0]  seq_phase_m;
    logic [cbs_pkg::TIME_W-1:0]   cycle_t0_ms;
    logic                         plan_on;
    logic                         latched;
    logic                         drive_on;
    logic [cbs_pkg::MV_W-1:0]     sample_mv;

    cbs_pkg::t_rsp              expected_status_q[$];
    int                         errors = 0;
    int                         idle_cycles;
    logic                       tx_idle_en;
    logic                       rx_idle_en;
    logic                       hold_off_req;
    logic [cbs_pkg::TIME_W-1:0] wall_ms;
    logic [cbs_pkg::TIME_W-1:0] ms_step_max;

    cell_balance_sequencer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic cbs_pkg::t_rsp advance_sequencer(input cbs_pkg::t_req r);
        cbs_pkg::t_rsp              s;
        logic [cbs_pkg::TIME_W-1:0] elapsed;
        if (r.action == cbs_pkg::ACT_SET) begin
            drive_on = r.balance_request;
        end else begin
            elapsed = r.now_ms - cycle_t0_ms;
            case (seq_phase_m)
                cbs_pkg::PH_SETTLE: begin
                    if (elapsed >= lim_settle_ms) seq_phase_m = cbs_pkg::PH_READ;
                end
                cbs_pkg::PH_READ: begin
                    sample_mv = r.cell_mv;
                    if (r.cell_mv >= lim_high_mv || latched) begin
                        if (r.cell_mv <= lim_release_mv) begin
                            latched = 1'b0;
                            plan_on = 1'b0;
                        end else begin
                            latched = 1'b1;
                            plan_on = 1'b1;
                        end
                    end
                    seq_phase_m = cbs_pkg::PH_RESTORE;
                end
                cbs_pkg::PH_RESTORE: begin
                    drive_on    = plan_on;
                    seq_phase_m = cbs_pkg::PH_WAIT;
                end
                cbs_pkg::PH_WAIT: begin
                    if (elapsed >= lim_interval_ms) seq_phase_m = cbs_pkg::PH_INITIAL;
                end
                default: begin
                    plan_on = drive_on;
                    if (drive_on) begin
                        drive_on    = 1'b0;
                        seq_phase_m = cbs_pkg::PH_SETTLE;
                    end else begin
                        seq_phase_m = cbs_pkg::PH_READ;
                    end
                    cycle_t0_ms = r.now_ms;
                end
            endcase
        end
        s.balancer_on  = drive_on;
        s.phase        = seq_phase_m;
        s.last_mv      = sample_mv;
        s.over_latched = latched;
        return s;
    endfunction

    function automatic int idle_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [cbs_pkg::MV_W-1:0] near_mv(
        input logic [cbs_pkg::MV_W-1:0] level);
        int v;
        v = int'(level) + int'($urandom_range(0, 40)) - 20;
        if (v < 0) v = 0;
        if (v > 8191) v = 8191;
        return v[cbs_pkg::MV_W-1:0];
    endfunction

    function automatic cbs_pkg::t_req random_request();
        cbs_pkg::t_req r;
        int unsigned   pick;
        logic [31:0]   rnd;
        pick              = $urandom_range(0, 99);
        rnd               = $urandom();
        r.action          = (pick < 8) ? cbs_pkg::ACT_SET : cbs_pkg::ACT_POLL;
        r.balance_request = 1'($urandom_range(0, 1));
        if (pick >= 95) begin
            r.now_ms = $urandom();
        end else begin
            wall_ms  = wall_ms + $urandom_range(0, ms_step_max);
            r.now_ms = wall_ms;
        end
        case ($urandom_range(0, 4))
            0:       r.cell_mv = rnd[cbs_pkg::MV_W-1:0];
            1, 2:    r.cell_mv = near_mv(lim_high_mv);
            default: r.cell_mv = near_mv(lim_release_mv);
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic send_request(input cbs_pkg::t_req r);
        int gap;
        if (tx_idle_en && $urandom_range(0, 99) < 40) gap = idle_length();
        else gap = 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_status_q.push_back(advance_sequencer(r));
    endtask

    task automatic poll(input logic [cbs_pkg::TIME_W-1:0] t,
                        input logic [cbs_pkg::MV_W-1:0] mv);
        cbs_pkg::t_req r;
        r.action          = cbs_pkg::ACT_POLL;
        r.now_ms          = t;
        r.cell_mv         = mv;
        r.balance_request = 1'($urandom_range(0, 1));
        send_request(r);
    endtask

    task automatic set_drive(input logic on);
        cbs_pkg::t_req r;
        logic [31:0]   rnd;
        rnd               = $urandom();
        r.action          = cbs_pkg::ACT_SET;
        r.now_ms          = $urandom();
        r.cell_mv         = rnd[cbs_pkg::MV_W-1:0];
        r.balance_request = on;
        send_request(r);
    endtask

    task automatic drain_outstanding();
        in_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cbs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cbs_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            cbs_pkg::CFG_HIGH_LEVEL:    lim_high_mv     = value[cbs_pkg::MV_W-1:0];
            cbs_pkg::CFG_RELEASE_LEVEL: lim_release_mv  = value[cbs_pkg::MV_W-1:0];
            cbs_pkg::CFG_SETTLE:        lim_settle_ms   = value[cbs_pkg::SETTLE_W-1:0];
            cbs_pkg::CFG_INTERVAL:      lim_interval_ms = value[cbs_pkg::TIME_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed_sequence();
        drain_outstanding();
        write_reg(CFG_SPARE, '1);
        poll(32'd0, 13'd0);
        poll(32'd10, 13'd4200);
        poll(32'd20, 13'd0);
        poll(32'd999, 13'd0);
        poll(32'd1000, 13'd0);
        poll(32'd1001, 13'd0);
        poll(32'd1100, 13'd0);
        poll(32'd1101, 13'd0);
        poll(32'd1102, 13'd4150);
        set_drive(1'b0);
        poll(32'd1103, 13'd0);
        poll(32'd2101, 13'd0);
        poll(32'd2102, 13'd0);
        poll(32'd2202, 13'd0);
        poll(32'd2203, 13'd4100);
        poll(32'd2204, 13'd0);
        set_drive(1'b1);
        // wrap of the millisecond counter across settle and interval
        poll(32'hFFFF_FFFF, 13'd0);
        poll(32'hFFFF_FFF0, 13'd0);
        poll(32'h0000_0054, 13'd0);
        poll(32'h0000_0055, 13'd8191);
        poll(32'h0000_0056, 13'd0);
        set_drive(1'b0);
        poll(32'h0000_03D7, 13'd0);
        poll(32'h0000_03D8, 13'd0);
    endtask

    task automatic test_config_extremes();
        drain_outstanding();
        // crossed levels, zero times
        write_reg(cbs_pkg::CFG_HIGH_LEVEL, '0);
        write_reg(cbs_pkg::CFG_RELEASE_LEVEL, '1);
        write_reg(cbs_pkg::CFG_SETTLE, '0);
        write_reg(cbs_pkg::CFG_INTERVAL, '0);
        ms_step_max = 2;
        repeat (20) send_request(random_request());
        drain_outstanding();
        write_reg(cbs_pkg::CFG_HIGH_LEVEL, '1);
        write_reg(cbs_pkg::CFG_RELEASE_LEVEL, '0);
        write_reg(cbs_pkg::CFG_SETTLE, '1);
        write_reg(cbs_pkg::CFG_INTERVAL, '1);
        ms_step_max = 32'h0001_0000;
        repeat (20) send_request(random_request());
    endtask

    task automatic test_backpressure();
        drain_outstanding();
        write_reg(cbs_pkg::CFG_HIGH_LEVEL, 32'(cbs_pkg::RST_HIGH_LEVEL));
        write_reg(cbs_pkg::CFG_RELEASE_LEVEL, 32'(cbs_pkg::RST_RELEASE_LEVEL));
        write_reg(cbs_pkg::CFG_SETTLE, 32'(cbs_pkg::RST_SETTLE));
        write_reg(cbs_pkg::CFG_INTERVAL, cbs_pkg::RST_INTERVAL);
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        ms_step_max  = 300;
        hold_off_req = 1'b1;
        repeat (80) send_request(random_request());
    endtask

    task automatic test_random_traffic();
        repeat (8) begin
            drain_outstanding();
            write_reg(cbs_pkg::CFG_HIGH_LEVEL,
                      ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(3000, 4500));
            write_reg(cbs_pkg::CFG_RELEASE_LEVEL, ($urandom_range(0, 9) == 0) ? $urandom()
                      : 32'(lim_high_mv) - $urandom_range(0, 300));
            write_reg(cbs_pkg::CFG_SETTLE,
                      ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 300));
            write_reg(cbs_pkg::CFG_INTERVAL,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                      : $urandom_range(50, 2000));
            if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom());
            ms_step_max = (lim_interval_ms + 32'(lim_settle_ms)) / 4 + 1;
            wall_ms     = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000)
                          : $urandom();
            tx_idle_en  = ($urandom_range(0, 3) != 0);
            rx_idle_en  = ($urandom_range(0, 3) != 0);
            repeat (225) send_request(random_request());
        end
    endtask

    initial begin : rx_stall_gen
        out_stall <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat (idle_length()) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin : status_check
        cbs_pkg::t_rsp want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_status_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, out_data);
                errors++;
            end else begin
                want = expected_status_q.pop_front();
                check_field("balancer_on", want.balancer_on, out_data.balancer_on);
                check_field("phase", want.phase, out_data.phase);
                check_field("last_mv", want.last_mv, out_data.last_mv);
                check_field("over_latched", want.over_latched, out_data.over_latched);
            end
        end
    end

    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("%0t timeout, %0d results outstanding", $time, expected_status_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : main_seq
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        tx_idle_en      = 1'b1;
        rx_idle_en      = 1'b1;
        hold_off_req    = 1'b0;
        wall_ms         = '0;
        ms_step_max     = 300;
        lim_high_mv     = cbs_pkg::RST_HIGH_LEVEL;
        lim_release_mv  = cbs_pkg::RST_RELEASE_LEVEL;
        lim_settle_ms   = cbs_pkg::RST_SETTLE;
        lim_interval_ms = cbs_pkg::RST_INTERVAL;
        seq_phase_m     = cbs_pkg::PH_INITIAL;
        cycle_t0_ms     = '0;
        plan_on         = 1'b0;
        latched         = 1'b0;
        drive_on        = 1'b0;
        sample_mv       = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_sequence();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();
        drain_outstanding();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
